[hw/rtl/tsa_pkg.sv]
// Shared types and constants for the tower slot allocator.
package tsa_pkg;

    localparam int TOWER_COUNT_DEF = 4;
    localparam int ROW_LIMIT_DEF   = 128;

    // Towers that have a row count register and a loading bit
    localparam int CFG_TOWERS = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Occupancy store word width
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        FUNC_FIND  = 2'd0,
        FUNC_ALLOC = 2'd1,
        FUNC_FREE  = 2'd2,
        FUNC_QUERY = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NONE    = 2'd1,
        ST_UNALLOC = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_T0 = 3'd0,
        CFG_ROWS_T1 = 3'd1,
        CFG_ROWS_T2 = 3'd2,
        CFG_ROWS_T3 = 3'd3,
        CFG_LOADING = 3'd4
    } cfg_idx_t;

endpackage

[hw/rtl/tsa_if.sv]
// Request and response channel interfaces of the tower slot allocator.
interface tsa_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [1:0] tower_sel;
    logic [6:0] row_sel;
    logic       check_taken;

    modport source (output valid, func, tower_sel, row_sel, check_taken, input ready);
    modport sink (input valid, func, tower_sel, row_sel, check_taken, output ready);
endinterface

interface tsa_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] found_tower;
    logic [6:0] found_row;
    logic       occupied;

    modport source (output valid, status, found_tower, found_row, occupied, input ready);
    modport sink (input valid, status, found_tower, found_row, occupied, output ready);
endinterface

[hw/rtl/tsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/tower_slot_allocator.sv]
// Tower slot allocator: first-fit occupancy bitmap over several towers.
// Query, allocate, free: the store word is read in S_RD and the result set in S_EVAL;
// out of range: the result is set in S_RD. Find: reads and checks one 32-bit word per pass,
// at most TOWER_COUNT*ceil(ROW_LIMIT/32) words; one RAM read per pass.
// One item at a time; ready returns the cycle after the result is taken.
// Reset clears a valid bit per store word, so every slot reads free at once.
module tower_slot_allocator #(
    parameter int TOWER_COUNT = tsa_pkg::TOWER_COUNT_DEF,
    parameter int ROW_LIMIT   = tsa_pkg::ROW_LIMIT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tsa_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [tsa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    tsa_req_if.sink                        req,
    tsa_rsp_if.source                      rsp
);

    localparam int WORD_W = tsa_pkg::WORD_W;
    localparam int BW     = $clog2(WORD_W);
    localparam int WPT    = (ROW_LIMIT + WORD_W - 1) / WORD_W;
    localparam int DEPTH  = TOWER_COUNT * WPT;
    localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int TW     = TOWER_COUNT > 1 ? $clog2(TOWER_COUNT) : 1;
    localparam int WW     = WPT > 1 ? $clog2(WPT) : 1;
    localparam int NW     = $clog2(ROW_LIMIT + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_EVAL = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [7:0] rows_reg [tsa_pkg::CFG_TOWERS];
    logic [tsa_pkg::CFG_TOWERS-1:0] loading_reg;
    logic [DEPTH-1:0] vld_reg;
    logic [TW-1:0] t_reg, t_next;
    logic [WW-1:0] w_reg, w_next;
    logic out_vld_reg, out_vld_next;

    // request latch and result registers (no reset)
    tsa_pkg::func_t func_reg;
    logic [1:0] twr_reg;
    logic [6:0] row_reg;
    logic chk_reg;
    logic rd_vld_reg;
    logic [1:0] status_reg, status_next;
    logic [1:0] ftower_reg, ftower_next;
    logic [6:0] frow_reg, frow_next;
    logic occ_reg, occ_next;

    logic accept;
    logic ram_we;
    logic [AW-1:0] scan_addr, tgt_addr, ram_raddr;
    logic [WORD_W-1:0] ram_rdata, word, new_word;
    logic tgt_ok;
    logic [NW-1:0] scan_rows;
    logic [WORD_W-1:0] cand;
    logic hit;
    logic [BW-1:0] first_idx;
    logic last_word;
    logic [BW-1:0] bit_sel;
    logic cur_occ;

    function automatic logic [NW-1:0] rows_of(input logic [TW-1:0] t);
        int ti;
        int r;
        ti = int'(t);
        if (ti >= tsa_pkg::CFG_TOWERS)
        begin
            return '0;
        end
        r = int'(rows_reg[2'(ti)]);
        if (r > ROW_LIMIT)
        begin
            r = ROW_LIMIT;
        end
        return NW'(r);
    endfunction

    function automatic logic loading_of(input logic [TW-1:0] t);
        int ti;
        ti = int'(t);
        if (ti >= tsa_pkg::CFG_TOWERS)
        begin
            return 1'b0;
        end
        return loading_reg[2'(ti)];
    endfunction

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && !out_vld_reg;

    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_tower = ftower_reg;
    assign rsp.found_row   = frow_reg;
    assign rsp.occupied    = occ_reg;

    // addresses
    assign scan_addr = AW'(int'(t_reg) * WPT + int'(w_reg));
    assign tgt_addr  = AW'(int'(TW'(twr_reg)) * WPT + int'(row_reg) / WORD_W);
    assign tgt_ok    = (int'(twr_reg) < TOWER_COUNT)
                       && (int'(row_reg) < int'(rows_of(TW'(int'(twr_reg)))));
    assign ram_raddr = (func_reg == tsa_pkg::FUNC_FIND) ? scan_addr : tgt_addr;
    assign bit_sel   = row_reg[BW-1:0];

    // a word never written reads as all free
    assign word    = rd_vld_reg ? ram_rdata : '0;
    assign cur_occ = word[bit_sel];

    // find: free bits of this word inside the tower's row count, none while the tower is loading
    assign scan_rows = rows_of(t_reg);
    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            cand[i] = !word[i] && !loading_of(t_reg)
                      && (int'(w_reg) * WORD_W + i < int'(scan_rows));
        end
    end

    always_comb
    begin
        first_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                first_idx = BW'(i);
            end
        end
    end

    assign hit       = |cand;
    assign last_word = (t_reg == TW'(TOWER_COUNT - 1)) && (w_reg == WW'(WPT - 1));

    always_comb
    begin
        new_word = word;
        if (func_reg == tsa_pkg::FUNC_ALLOC)
        begin
            new_word[bit_sel] = 1'b1;
        end
        else
        begin
            new_word[bit_sel] = 1'b0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        t_next       = t_reg;
        w_next       = w_reg;
        out_vld_next = out_vld_reg && !rsp.ready;
        status_next  = status_reg;
        ftower_next  = ftower_reg;
        frow_next    = frow_reg;
        occ_next     = occ_reg;
        ram_we       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RD;
                    t_next     = '0;
                    w_next     = '0;
                end
            end
            S_RD:
            begin
                if (func_reg != tsa_pkg::FUNC_FIND && !tgt_ok)
                begin
                    status_next  = tsa_pkg::ST_RANGE;
                    ftower_next  = '0;
                    frow_next    = '0;
                    occ_next     = 1'b0;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (func_reg == tsa_pkg::FUNC_FIND)
                begin
                    occ_next = 1'b0;
                    if (hit)
                    begin
                        status_next  = tsa_pkg::ST_OK;
                        ftower_next  = 2'(int'(t_reg));
                        frow_next    = 7'(int'(w_reg) * WORD_W + int'(first_idx));
                        out_vld_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (last_word)
                    begin
                        status_next  = tsa_pkg::ST_NONE;
                        ftower_next  = '0;
                        frow_next    = '0;
                        out_vld_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        if (w_reg == WW'(WPT - 1))
                        begin
                            w_next = '0;
                            t_next = t_reg + TW'(1);
                        end
                        else
                        begin
                            w_next = w_reg + WW'(1);
                        end
                        state_next = S_RD;
                    end
                end
                else
                begin
                    ftower_next = '0;
                    frow_next   = '0;
                    occ_next    = cur_occ;
                    status_next = tsa_pkg::ST_OK;
                    unique case (func_reg)
                        tsa_pkg::FUNC_ALLOC:
                        begin
                            if (cur_occ && chk_reg)
                            begin
                                status_next = tsa_pkg::ST_NONE;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                            end
                        end
                        tsa_pkg::FUNC_FREE:
                        begin
                            if (!cur_occ)
                            begin
                                status_next = tsa_pkg::ST_UNALLOC;
                            end
                            ram_we = 1'b1;
                        end
                        default:
                        begin
                            ram_we = 1'b0;
                        end
                    endcase
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    tsa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(tgt_addr),
        .wdata(new_word),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            t_reg       <= '0;
            w_reg       <= '0;
            out_vld_reg <= 1'b0;
            vld_reg     <= '0;
            rows_reg[0] <= 8'd4;
            rows_reg[1] <= 8'd94;
            rows_reg[2] <= 8'd94;
            rows_reg[3] <= 8'd94;
            loading_reg <= 4'b0001;
        end
        else
        begin
            state_reg   <= state_next;
            t_reg       <= t_next;
            w_reg       <= w_next;
            out_vld_reg <= out_vld_next;
            if (ram_we)
            begin
                vld_reg[tgt_addr] <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    tsa_pkg::CFG_ROWS_T0: rows_reg[0] <= cfg_wdata;
                    tsa_pkg::CFG_ROWS_T1: rows_reg[1] <= cfg_wdata;
                    tsa_pkg::CFG_ROWS_T2: rows_reg[2] <= cfg_wdata;
                    tsa_pkg::CFG_ROWS_T3: rows_reg[3] <= cfg_wdata;
                    tsa_pkg::CFG_LOADING: loading_reg <= cfg_wdata[3:0];
                    default:              loading_reg <= loading_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= tsa_pkg::func_t'(req.func);
            twr_reg  <= req.tower_sel;
            row_reg  <= req.row_sel;
            chk_reg  <= req.check_taken;
        end
        rd_vld_reg <= vld_reg[ram_raddr];
        status_reg <= status_next;
        ftower_reg <= ftower_next;
        frow_reg   <= frow_next;
        occ_reg    <= occ_next;
    end

endmodule
